[src/sbcs_pkg.sv]
// shared types, constants and sizes for the sticky box collision store
package sbcs_pkg;

  localparam int MAX_PARTICLES = 64;
  localparam int COORD_W       = 24;
  localparam int RADIUS_W      = 20;
  localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);
  localparam int IDX_W         = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int STEP_W        = $clog2(MAX_PARTICLES + 3);
  localparam int DIFF_W        = COORD_W + 1;
  localparam int SQ_W          = 2 * DIFF_W;
  localparam int SUM_W         = SQ_W + 2;
  localparam int LIMIT_W       = 2 * RADIUS_W + 2;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(65536);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [RADIUS_W-1:0]       radius_t;
  typedef logic [LIMIT_W-1:0]        limit_t;
  typedef logic [CNT_W-1:0]          count_t;

  typedef enum logic [1:0] {
    OP_NEW   = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } centre_t;

  typedef struct packed {
    logic [1:0] operation;
    coord_t     pos_x;
    coord_t     pos_y;
    coord_t     pos_z;
  } in_t;

  typedef struct packed {
    logic   inside_box;
    logic   collided;
    logic   rejected_full;
    count_t stored_count;
  } out_t;

  // control of one storage cell
  typedef struct packed {
    logic load;
    logic from_input;
  } cell_ctrl_t;

endpackage

[src/sbcs_cell.sv]
// one storage cell of the centre ring: holds a centre, takes the neighbor's or a new one
module sbcs_cell (
  input  logic                 clk_i,
  input  sbcs_pkg::cell_ctrl_t ctrl_i,
  input  sbcs_pkg::centre_t    prev_i,
  input  sbcs_pkg::centre_t    new_i,
  output sbcs_pkg::centre_t    centre_o
);

  sbcs_pkg::centre_t centre_q, centre_d;

  always_comb begin
    centre_d = centre_q;
    if (ctrl_i.load) begin
      centre_d = ctrl_i.from_input ? new_i : prev_i;
    end
  end

  always_ff @(posedge clk_i) begin
    centre_q <= centre_d;
  end

  assign centre_o = centre_q;

endmodule

[src/sbcs_dist.sv]
// pipelined squared distance unit: abs diff, square, sum, compare against limit
module sbcs_dist (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                issue_i,
  input  sbcs_pkg::centre_t   point_i,
  input  sbcs_pkg::centre_t   centre_i,
  input  sbcs_pkg::limit_t    limit_i,
  output logic                match_o
);

  localparam int DW = sbcs_pkg::DIFF_W;
  localparam int QW = sbcs_pkg::SQ_W;
  localparam int SW = sbcs_pkg::SUM_W;

  logic [DW-1:0] abs_d [3];
  logic [DW-1:0] abs_q [3];
  logic [QW-1:0] sq_q  [3];
  logic [SW-1:0] sum_q;
  logic          va_q, vb_q, vc_q;
  logic          va_d, vb_d, vc_d;
  logic signed [DW-1:0] diff [3];
  sbcs_pkg::coord_t pc [3];
  sbcs_pkg::coord_t cc [3];

  assign pc[0] = point_i.x;
  assign pc[1] = point_i.y;
  assign pc[2] = point_i.z;
  assign cc[0] = centre_i.x;
  assign cc[1] = centre_i.y;
  assign cc[2] = centre_i.z;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      diff[a]  = DW'(pc[a]) - DW'(cc[a]);
      abs_d[a] = diff[a][DW-1] ? DW'(-diff[a]) : DW'(diff[a]);
    end
    va_d = issue_i;
    vb_d = va_q;
    vc_d = vb_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= va_d;
      vb_q <= vb_d;
      vc_q <= vc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      abs_q[a] <= abs_d[a];
      sq_q[a]  <= QW'(abs_q[a]) * QW'(abs_q[a]);
    end
    sum_q <= SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]);
  end

  assign match_o = vc_q & (sum_q < SW'(limit_i));

endmodule

[src/sticky_box_collision_store.sv]
// top level: box tracking, centre ring of cells and query sequencer
// results: new group, add and unused codes give their result in the cycle after the beat is taken
// query: the whole centre ring is rotated once past a single 3-stage squared distance unit,
//   then that pipeline drains before the result is written
// throughput: one item at a time; a new beat is taken in the cycle the waiting result leaves
// reset: box and count cleared, radius 65536; the centre cells hold no reset value
module sticky_box_collision_store (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  sbcs_pkg::in_t              in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output sbcs_pkg::out_t             out_data_o,
  input  logic                       cfg_we_i,
  input  logic [sbcs_pkg::RADIUS_W-1:0] cfg_data_i
);

  localparam int N  = sbcs_pkg::MAX_PARTICLES;
  localparam int CW = sbcs_pkg::COORD_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // saturate a widened coordinate back into the signed 24-bit range
  function automatic sbcs_pkg::coord_t sat_coord(logic signed [CW+1:0] v);
    sbcs_pkg::coord_t r;
    if (v > $signed({3'b000, {(CW - 1){1'b1}}})) begin
      r = {1'b0, {(CW - 1){1'b1}}};
    end else if (v < $signed({3'b111, {(CW - 1){1'b0}}})) begin
      r = {1'b1, {(CW - 1){1'b0}}};
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  state_e                 state_q, state_d;
  sbcs_pkg::radius_t      radius_q, radius_d;
  sbcs_pkg::count_t       count_q, count_d;
  sbcs_pkg::coord_t       box_lo_q [3];
  sbcs_pkg::coord_t       box_lo_d [3];
  sbcs_pkg::coord_t       box_hi_q [3];
  sbcs_pkg::coord_t       box_hi_d [3];
  sbcs_pkg::out_t         out_q, out_d;
  logic                   out_valid_q, out_valid_d;
  logic [sbcs_pkg::STEP_W-1:0] step_q, step_d;
  logic                   hit_q, hit_d;
  logic                   inside_q, inside_d;
  sbcs_pkg::centre_t      point_q, point_d;
  sbcs_pkg::limit_t       limit_q, limit_d;

  logic                   accept;
  logic                   out_free;
  logic                   rotate;
  logic                   add_ok;
  logic                   new_grp;
  logic                   issue;
  logic                   match;
  logic                   inside_now;
  logic [sbcs_pkg::IDX_W-1:0] scan_idx;
  logic [2*sbcs_pkg::RADIUS_W-1:0] r_sq;
  logic signed [CW+1:0]   wide_lo [3];
  logic signed [CW+1:0]   wide_hi [3];
  sbcs_pkg::coord_t       pt [3];
  sbcs_pkg::centre_t      in_centre;
  sbcs_pkg::centre_t      cell_q [N];
  sbcs_pkg::cell_ctrl_t   head_ctrl, body_ctrl;

  assign pt[0] = in_data_i.pos_x;
  assign pt[1] = in_data_i.pos_y;
  assign pt[2] = in_data_i.pos_z;
  assign in_centre = '{x: in_data_i.pos_x, y: in_data_i.pos_y, z: in_data_i.pos_z};

  // handshake: input waits while a query runs or the result slot is blocked
  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) | ~out_free;
  assign accept     = in_valid_i & ~in_stall_o;

  assign new_grp = accept & (in_data_i.operation == sbcs_pkg::OP_NEW);
  assign add_ok  = accept & (in_data_i.operation == sbcs_pkg::OP_ADD) &
                   (count_q != sbcs_pkg::count_t'(N));

  // the ring turns once per query; cell N-1 feeds the distance unit
  assign rotate   = (state_q == ST_SCAN) & (step_q < sbcs_pkg::STEP_W'(N));
  assign scan_idx = sbcs_pkg::IDX_W'(N - 1) - step_q[sbcs_pkg::IDX_W-1:0];
  assign issue    = rotate & (sbcs_pkg::count_t'(scan_idx) < count_q);

  // head cell takes a new centre on a non-full add or new group, else the tail on rotation
  assign head_ctrl = '{load: rotate | add_ok | new_grp, from_input: ~rotate};
  assign body_ctrl = '{load: rotate | add_ok, from_input: 1'b0};

  for (genvar g = 0; g < N; g++) begin : g_cell
    if (g == 0) begin : g_head
      sbcs_cell u_cell (
        .clk_i    (clk_i),
        .ctrl_i   (head_ctrl),
        .prev_i   (cell_q[N-1]),
        .new_i    (in_centre),
        .centre_o (cell_q[g])
      );
    end else begin : g_body
      sbcs_cell u_cell (
        .clk_i    (clk_i),
        .ctrl_i   (body_ctrl),
        .prev_i   (cell_q[g-1]),
        .new_i    (in_centre),
        .centre_o (cell_q[g])
      );
    end
  end

  sbcs_dist u_dist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .issue_i  (issue),
    .point_i  (point_q),
    .centre_i (cell_q[N-1]),
    .limit_i  (limit_q),
    .match_o  (match)
  );

  assign r_sq = radius_q * radius_q;

  always_comb begin
    inside_now = 1'b1;
    for (int a = 0; a < 3; a++) begin
      wide_lo[a] = (CW + 2)'(pt[a]) - $signed({{(CW + 2 - sbcs_pkg::RADIUS_W){1'b0}}, radius_q});
      wide_hi[a] = (CW + 2)'(pt[a]) + $signed({{(CW + 2 - sbcs_pkg::RADIUS_W){1'b0}}, radius_q});
      if (pt[a] < box_lo_q[a] || pt[a] > box_hi_q[a]) begin
        inside_now = 1'b0;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    radius_d    = cfg_we_i ? cfg_data_i : radius_q;
    count_d     = count_q;
    box_lo_d    = box_lo_q;
    box_hi_d    = box_hi_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & out_stall_i;
    step_d      = step_q;
    hit_d       = hit_q;
    inside_d    = inside_q;
    point_d     = point_q;
    limit_d     = limit_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_d = '{inside_box: 1'b0, collided: 1'b0, rejected_full: 1'b0,
                    stored_count: count_q};
          case (in_data_i.operation)
            sbcs_pkg::OP_NEW: begin
              for (int a = 0; a < 3; a++) begin
                box_lo_d[a] = sat_coord(wide_lo[a]);
                box_hi_d[a] = sat_coord(wide_hi[a]);
              end
              count_d            = sbcs_pkg::count_t'(1);
              out_d.stored_count = sbcs_pkg::count_t'(1);
              out_valid_d        = 1'b1;
            end
            sbcs_pkg::OP_ADD: begin
              if (add_ok) begin
                for (int a = 0; a < 3; a++) begin
                  if (pt[a] < box_lo_q[a]) box_lo_d[a] = pt[a];
                  if (pt[a] > box_hi_q[a]) box_hi_d[a] = pt[a];
                end
                count_d            = count_q + sbcs_pkg::count_t'(1);
                out_d.stored_count = count_q + sbcs_pkg::count_t'(1);
              end else begin
                out_d.rejected_full = 1'b1;
              end
              out_valid_d = 1'b1;
            end
            sbcs_pkg::OP_QUERY: begin
              point_d  = in_centre;
              limit_d  = {r_sq, 2'b00};
              inside_d = inside_now;
              hit_d    = 1'b0;
              step_d   = '0;
              state_d  = ST_SCAN;
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        hit_d = hit_q | match;
        // wait until the last centre has left the distance pipeline
        if (step_q == sbcs_pkg::STEP_W'(N + 2)) begin
          state_d = ST_DONE;
        end else begin
          step_d = step_q + sbcs_pkg::STEP_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_d = '{inside_box: inside_q, collided: hit_q, rejected_full: 1'b0,
                    stored_count: count_q};
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      radius_q    <= sbcs_pkg::RADIUS_RESET;
      count_q     <= '0;
      box_lo_q    <= '{default: '0};
      box_hi_q    <= '{default: '0};
      out_q       <= '0;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      hit_q       <= 1'b0;
      inside_q    <= 1'b0;
      point_q     <= '0;
      limit_q     <= '0;
    end else begin
      state_q     <= state_d;
      radius_q    <= radius_d;
      count_q     <= count_d;
      box_lo_q    <= box_lo_d;
      box_hi_q    <= box_hi_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      hit_q       <= hit_d;
      inside_q    <= inside_d;
      point_q     <= point_d;
      limit_q     <= limit_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[tb/sbcs_tb_pkg.sv]
`timescale 1ns / 100ps
// scoreboard class that predicts and checks the flags of the sticky box collision store
package sbcs_tb_pkg;
  import sbcs_pkg::*;

  function automatic coord_t clamp_coord(input longint v);
    if (v > longint'(8388607)) return coord_t'(24'h7FFFFF);
    if (v < -longint'(8388608)) return coord_t'(24'h800000);
    return coord_t'(v);
  endfunction

  class flag_board;
    radius_t              radius;
    coord_t               box_lo [3];
    logic [COORD_W-1:0]   box_ext [3];
    coord_t               centres [MAX_PARTICLES][3];
    int unsigned          count;
    out_t                 pending_flags [$];
    int unsigned          errors;
    int unsigned          results_seen;

    function new();
      radius       = RADIUS_RESET;
      count        = 0;
      errors       = 0;
      results_seen = 0;
      foreach (box_lo[a]) begin
        box_lo[a]  = '0;
        box_ext[a] = '0;
      end
    endfunction

    function void set_radius(input radius_t r);
      radius = r;
    endfunction

    function int unsigned pending();
      return pending_flags.size();
    endfunction

    // work out the flags of one accepted beat and move the box state on
    function void take_item(input in_t it);
      out_t   want;
      longint p [3];
      longint lo, hi, lim, d, d2;
      int unsigned n;
      p[0] = longint'($signed(it.pos_x));
      p[1] = longint'($signed(it.pos_y));
      p[2] = longint'($signed(it.pos_z));
      want = '0;
      case (it.operation)
        OP_NEW: begin
          for (int a = 0; a < 3; a++) begin
            lo = longint'(clamp_coord(p[a] - longint'(radius)));
            hi = longint'(clamp_coord(p[a] + longint'(radius)));
            box_lo[a]     = coord_t'(lo);
            box_ext[a]    = COORD_W'(hi - lo);
            centres[0][a] = coord_t'(p[a]);
          end
          count = 1;
        end
        OP_ADD: begin
          if (count >= MAX_PARTICLES) begin
            want.rejected_full = 1'b1;
          end else begin
            for (int a = 0; a < 3; a++) begin
              lo = longint'(box_lo[a]);
              hi = lo + longint'(box_ext[a]);
              if (p[a] < lo) lo = p[a];
              if (p[a] > hi) hi = p[a];
              box_lo[a]         = coord_t'(lo);
              box_ext[a]        = COORD_W'(hi - lo);
              centres[count][a] = coord_t'(p[a]);
            end
            count++;
          end
        end
        OP_QUERY: begin
          lim = 4 * longint'(radius) * longint'(radius);
          want.inside_box = 1'b1;
          for (int a = 0; a < 3; a++) begin
            lo = longint'(box_lo[a]);
            hi = lo + longint'(box_ext[a]);
            if (p[a] < lo || p[a] > hi) want.inside_box = 1'b0;
          end
          for (n = 0; n < count; n++) begin
            d2 = 0;
            for (int a = 0; a < 3; a++) begin
              d  = p[a] - longint'(centres[n][a]);
              d2 += (d < 0 ? -d : d) * (d < 0 ? -d : d);
            end
            if (d2 < lim) begin
              want.collided = 1'b1;
              break;
            end
          end
        end
        default: ;
      endcase
      want.stored_count = count_t'(count);
      pending_flags = {pending_flags, want};
    endfunction

    function void check_result(input out_t got);
      out_t want;
      results_seen++;
      if (pending_flags.size() == 0) begin
        $error("result beat with no item waiting: %p", got);
        errors++;
        return;
      end
      want = pending_flags.pop_front();
      if (got.inside_box !== want.inside_box) begin
        $error("inside_box: expected %0d, got %0d", want.inside_box, got.inside_box);
        errors++;
      end
      if (got.collided !== want.collided) begin
        $error("collided: expected %0d, got %0d", want.collided, got.collided);
        errors++;
      end
      if (got.rejected_full !== want.rejected_full) begin
        $error("rejected_full: expected %0d, got %0d", want.rejected_full, got.rejected_full);
        errors++;
      end
      if (got.stored_count !== want.stored_count) begin
        $error("stored_count: expected %0d, got %0d", want.stored_count, got.stored_count);
        errors++;
      end
    endfunction
  endclass

endpackage

[tb/sticky_box_collision_store_test.sv]
`timescale 1ns / 100ps
// testbench top: directed and random beats against the sticky box collision store
module sticky_box_collision_store_test;
  import sbcs_pkg::*;
  import sbcs_tb_pkg::*;

  localparam int          CLK_HALF     = 4;
  localparam int          RESET_CYCLES = 9;
  localparam int unsigned N_ITEMS      = 1950;
  localparam int unsigned N_DIRECTED   = 18;
  localparam int          N_PHASES     = 6;
  localparam int unsigned CYCLE_LIMIT  = 1500000;
  // a query walks the whole ring, so drain a little longer than that
  localparam int          DRAIN_CYCLES = MAX_PARTICLES + 16;
  // long receiver hold-off, started once this many results are in
  localparam int unsigned HOLD_AFTER   = 300;
  localparam int          HOLD_CYCLES  = 600;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam coord_t     C_MAX     = coord_t'(24'h7FFFFF);
  localparam coord_t     C_MIN     = coord_t'(24'h800000);
  localparam coord_t     ONE       = coord_t'(24'h010000);

  logic    clk_i     = 1'b0;
  logic    rst_ni    = 1'b0;
  logic    in_valid  = 1'b0;
  in_t     in_data   = '0;
  logic    in_stall;
  logic    out_valid;
  logic    out_stall = 1'b0;
  out_t    out_data;
  logic    cfg_we    = 1'b0;
  radius_t cfg_data  = '0;

  flag_board   board = new();
  int unsigned cycles = 0;
  int unsigned sent = 0;
  bit          quiet = 1'b0;
  bit          hold_done = 1'b0;
  // centre of the group being built, random adds and queries cluster around it
  coord_t      anchor [3] = '{default: '0};

  sticky_box_collision_store u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // hard stop in case the handshake hangs
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("sticky_box_collision_store_test: FAIL");
      $finish;
    end
  end

  // every accepted result beat goes against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      board.check_result(out_data);
    end
  end

  // idle length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  function automatic coord_t near(input coord_t c, input int unsigned span);
    return clamp_coord(longint'(c) + longint'($urandom_range(0, 2 * span)) - longint'(span));
  endfunction

  function automatic in_t beat_of(input logic [1:0] op, input coord_t x, input coord_t y,
                                  input coord_t z);
    in_t it;
    it.operation = op;
    it.pos_x     = x;
    it.pos_y     = y;
    it.pos_z     = z;
    return it;
  endfunction

  // offer one beat, hold it until taken, then maybe leave a gap
  task automatic send(input in_t it);
    int unsigned n;
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    board.take_item(it);
    if (it.operation != OP_UNUSED) sent++;
    // toggle runs of back-to-back beats
    if ($urandom_range(0, 49) == 0) quiet = !quiet;
    n = quiet ? 0 : idle_len();
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // radius writes only once every result is back and the input is quiet
  task automatic set_radius(input radius_t r);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    cfg_data <= r;
    cfg_we   <= 1'b1;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    board.set_radius(r);
  endtask

  task automatic new_group();
    foreach (anchor[a]) begin
      anchor[a] = ($urandom_range(0, 9) < 7) ? near('0, 1 << 21) : coord_t'($urandom);
    end
    send(beat_of(OP_NEW, anchor[0], anchor[1], anchor[2]));
  endtask

  task automatic add_near(input int unsigned span);
    coord_t c [3];
    if ($urandom_range(0, 9) == 0) begin
      foreach (c[a]) c[a] = coord_t'($urandom);
    end else begin
      foreach (c[a]) c[a] = near(anchor[a], 4 * span);
    end
    send(beat_of(OP_ADD, c[0], c[1], c[2]));
  endtask

  // query next to a stored centre, around the group, or anywhere
  task automatic query_near(input int unsigned span);
    int unsigned pick, idx;
    coord_t      q [3];
    pick = $urandom_range(0, 99);
    if (pick < 50 && board.count != 0) begin
      idx = $urandom_range(0, board.count - 1);
      foreach (q[a]) q[a] = near(board.centres[idx][a], span);
    end else if (pick < 85) begin
      foreach (q[a]) q[a] = near(anchor[a], 3 * span);
    end else begin
      foreach (q[a]) q[a] = coord_t'($urandom);
    end
    send(beat_of(OP_QUERY, q[0], q[1], q[2]));
  endtask

  // run the store up to its limit, ending a little short of or past full
  task automatic fill_store(input int unsigned span);
    int n;
    if ($urandom_range(0, 1) == 1) new_group();
    n = MAX_PARTICLES - int'(board.count) + int'($urandom_range(0, 6)) - 1;
    repeat (n) add_near(span);
  endtask

  // output side stall pattern, with one long hold-off so the block backs up
  initial begin : receiver
    int unsigned n;
    forever begin
      if (!hold_done && board.results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        n = idle_len();
        out_stall <= (n != 0);
        if (n == 0) n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 6);
        repeat (n) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    int unsigned span, stop, pick, budget;
    radius_t     r;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, radius still at its reset value of one
    // reset box is a single point at the origin, store empty
    send(beat_of(OP_QUERY, '0, '0, '0));
    send(beat_of(OP_QUERY, coord_t'(1), '0, '0));
    // unused code with extreme fields changes nothing
    send(beat_of(OP_UNUSED, C_MAX, C_MIN, coord_t'(-1)));
    // add with no group yet widens the reset box
    send(beat_of(OP_ADD, coord_t'(2 * ONE), coord_t'(-3 * ONE), coord_t'(ONE / 2)));
    send(beat_of(OP_QUERY, ONE, coord_t'(-3 * ONE), coord_t'(ONE / 2)));
    // new group at the top corner saturates the high bound
    send(beat_of(OP_NEW, C_MAX, C_MAX, C_MAX));
    send(beat_of(OP_QUERY, C_MAX, C_MAX, C_MAX));
    // exactly two radii away is no hit, one lsb closer is
    send(beat_of(OP_QUERY, coord_t'(C_MAX - 2 * ONE), C_MAX, C_MAX));
    send(beat_of(OP_QUERY, coord_t'(C_MAX - 2 * ONE + 1), C_MAX, C_MAX));
    // low corner saturates, then one add spans the full range
    send(beat_of(OP_NEW, C_MIN, C_MIN, C_MIN));
    send(beat_of(OP_ADD, C_MAX, C_MAX, C_MAX));
    send(beat_of(OP_QUERY, C_MIN, C_MAX, C_MIN));
    send(beat_of(OP_QUERY, C_MAX, C_MIN, C_MAX));
    send(beat_of(OP_NEW, '0, '0, '0));
    send(beat_of(OP_ADD, coord_t'(-1), coord_t'(-1), coord_t'(-1)));
    send(beat_of(OP_ADD, coord_t'(C_MIN + 1), coord_t'(1), coord_t'(C_MAX - 1)));
    send(beat_of(OP_QUERY, -ONE, -ONE, -ONE));
    send(beat_of(OP_QUERY, coord_t'(2 * ONE), '0, '0));

    // random phases, each under its own radius, extremes included
    budget = (N_ITEMS - N_DIRECTED) / N_PHASES;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0:       r = RADIUS_RESET;
        1:       r = '0;
        2:       r = '1;
        3:       r = radius_t'($urandom_range(1, 4096));
        4:       r = radius_t'($urandom_range(4097, 1048574));
        default: r = '1;
      endcase
      set_radius(r);
      span = 3 * int'(board.radius) + 2;
      stop = sent + budget;
      // new radius against the box as it stands
      repeat (3) query_near(span);
      if (ph == 0) fill_store(span);
      while (sent < stop) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) new_group();
        else if (pick < 45) add_near(span);
        else if (pick < 94) query_near(span);
        else if (pick < 99) begin
          send(beat_of(OP_UNUSED, coord_t'($urandom), coord_t'($urandom),
                       coord_t'($urandom)));
        end else fill_store(span);
      end
    end

    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    // catch any stray result beats
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("sticky_box_collision_store_test: PASS");
    end else begin
      $display("sticky_box_collision_store_test: FAIL");
    end
    $finish;
  end

endmodule
